/* sv/i2cbm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbm_pkg
// shared types and constants of the byte-level i2c master sequencer
// ----------------------------------------------------------------------------
package i2cbm_pkg;

  // command codes on the input beat
  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_WRITE = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;

  // active operation, one-hot
  typedef enum logic [4:0] {
    OP_IDLE  = 5'b00001,
    OP_START = 5'b00010,
    OP_STOP  = 5'b00100,
    OP_WRITE = 5'b01000,
    OP_READ  = 5'b10000
  } op_e;

  localparam int unsigned PhaseW = 5;

  // phase plan landmarks
  localparam logic [PhaseW-1:0] LAST_START = 5'd2;
  localparam logic [PhaseW-1:0] LAST_STOP  = 5'd2;
  localparam logic [PhaseW-1:0] LAST_WRITE = 5'd17;
  localparam logic [PhaseW-1:0] LAST_READ  = 5'd18;
  localparam logic [PhaseW-1:0] ACK_PHASE  = 5'd16;
  localparam logic [PhaseW-1:0] ACK_LOW    = 5'd17;

  // one result beat
  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic [7:0] read_data;
    logic       ack_seen;
  } res_t;

endpackage

/* sv/i2c_bit_level_master_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_bit_level_master_unit
// byte-level i2c master: one input beat per bus phase tick, one result beat out
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid_i / in_ready_o): one beat per bus phase tick,
//   carrying the sampled sda level and, when idle, a command (start, stop,
//   write byte, read byte). commands that arrive while busy are dropped.
//   output channel (out_valid_o / out_ready_i): exactly one result beat per
//   input beat, with the scl/sda levels for that phase, busy/done flags, the
//   last read byte and the last write ack sample.
//   timing: a beat's result is registered and shown in the cycle after
//   it is accepted. throughput: one beat per clock while unstalled, set by the
//   single registered pass through the phase sequencer and output register.
//   stall: while a result waits and out_ready_i is low, in_ready_o drops; the
//   sequencer state only moves on accepted beats, so nothing is lost.
//   reset: lines released high, sequencer idle, read byte and ack flag zero,
//   output register empty.
// ----------------------------------------------------------------------------
module i2c_bit_level_master_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] command_i,
  input  logic [7:0] write_data_i,
  input  logic       send_ack_i,
  input  logic       sda_in_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       scl_out_o,
  output logic       sda_out_o,
  output logic       busy_res_o,
  output logic       done_res_o,
  output logic [7:0] read_data_o,
  output logic       ack_seen_o
);

  logic            in_fire;
  logic            out_valid_q, out_valid_d;
  i2cbm_pkg::res_t res_d, res_q;

  // take a new beat whenever the output slot is empty or being drained
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // sequencer state advances only on accepted beats
  i2cbm_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (in_fire),
    .cmd_i        (command_i),
    .write_data_i (write_data_i),
    .send_ack_i   (send_ack_i),
    .sda_in_i     (sda_in_i),
    .res_o        (res_d)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, loaded with each accepted beat
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign scl_out_o   = res_q.scl;
  assign sda_out_o   = res_q.sda;
  assign busy_res_o  = res_q.busy;
  assign done_res_o  = res_q.done;
  assign read_data_o = res_q.read_data;
  assign ack_seen_o  = res_q.ack_seen;

`ifndef NO_ASSERTIONS
  // every accepted beat shows up as a result next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("accepted beat produced no result");

  // a finishing phase is always a busy phase
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.done |-> res_q.busy)
    else $error("done without busy");

  // a held result blocks the input side
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !in_fire)
    else $error("beat accepted over a stalled result");
`endif

endmodule

/* sv/i2cbm_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbm_seq
// phase sequencer: takes a command when idle, advances one bus phase per step
// ----------------------------------------------------------------------------
module i2cbm_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [2:0]        cmd_i,
  input  logic [7:0]        write_data_i,
  input  logic              send_ack_i,
  input  logic              sda_in_i,
  output i2cbm_pkg::res_t   res_o
);

  i2cbm_pkg::op_e                    op_q, op_d, op_run;
  logic [i2cbm_pkg::PhaseW-1:0]      phase_q, phase_d, phase_run, last_phase;
  logic [7:0]                        shift_q, shift_d, shift_run;
  logic [7:0]                        last_read_q, last_read_d;
  logic                              ack_choice_q, ack_choice_d;
  logic                              scl_q, scl_d, sda_q, sda_d;
  logic                              ack_flag_q, ack_flag_d;
  logic                              busy, done;

  always_comb begin
    // command pickup
    op_run       = op_q;
    phase_run    = phase_q;
    shift_run    = shift_q;
    ack_choice_d = ack_choice_q;
    if (op_q == i2cbm_pkg::OP_IDLE) begin
      phase_run = '0;
      case (cmd_i)
        i2cbm_pkg::CMD_START: op_run = i2cbm_pkg::OP_START;
        i2cbm_pkg::CMD_STOP:  op_run = i2cbm_pkg::OP_STOP;
        i2cbm_pkg::CMD_WRITE: begin
          op_run    = i2cbm_pkg::OP_WRITE;
          shift_run = write_data_i;
        end
        i2cbm_pkg::CMD_READ: begin
          op_run       = i2cbm_pkg::OP_READ;
          shift_run    = '0;
          ack_choice_d = send_ack_i;
        end
        default: ;
      endcase
    end

    // run one phase
    scl_d       = scl_q;
    sda_d       = sda_q;
    shift_d     = shift_run;
    ack_flag_d  = ack_flag_q;
    last_read_d = last_read_q;
    last_phase  = '0;
    busy        = 1'b1;
    case (op_run)
      i2cbm_pkg::OP_START: begin
        last_phase = i2cbm_pkg::LAST_START;
        if (phase_run == 5'd0) begin
          sda_d = 1'b1;
          scl_d = 1'b1;
        end else if (phase_run == 5'd1) begin
          sda_d = 1'b0;
        end else begin
          scl_d = 1'b0;
        end
      end
      i2cbm_pkg::OP_STOP: begin
        last_phase = i2cbm_pkg::LAST_STOP;
        if (phase_run == 5'd0) begin
          sda_d = 1'b0;
        end else if (phase_run == 5'd1) begin
          scl_d = 1'b1;
        end else begin
          sda_d = 1'b1;
        end
      end
      i2cbm_pkg::OP_WRITE: begin
        last_phase = i2cbm_pkg::LAST_WRITE;
        if (phase_run < i2cbm_pkg::ACK_PHASE) begin
          if (!phase_run[0]) begin
            sda_d = shift_run[7];
            scl_d = 1'b1;
          end else begin
            scl_d   = 1'b0;
            shift_d = {shift_run[6:0], 1'b0};
          end
        end else if (phase_run == i2cbm_pkg::ACK_PHASE) begin
          sda_d = 1'b1;
          scl_d = 1'b1;
        end else begin
          scl_d      = 1'b0;
          ack_flag_d = sda_in_i;
        end
      end
      i2cbm_pkg::OP_READ: begin
        last_phase = i2cbm_pkg::LAST_READ;
        if (phase_run < i2cbm_pkg::ACK_PHASE) begin
          if (!phase_run[0]) begin
            sda_d = 1'b1;
            scl_d = 1'b1;
          end else begin
            scl_d   = 1'b0;
            shift_d = {shift_run[6:0], sda_in_i};
          end
        end else if (phase_run == i2cbm_pkg::ACK_PHASE) begin
          sda_d = ~ack_choice_d;
          scl_d = 1'b1;
        end else if (phase_run == i2cbm_pkg::ACK_LOW) begin
          scl_d = 1'b0;
        end else begin
          last_read_d = shift_run;
        end
      end
      default: busy = 1'b0;
    endcase

    // advance or finish
    done    = 1'b0;
    op_d    = op_run;
    phase_d = phase_run;
    if (busy) begin
      if (phase_run >= last_phase) begin
        done    = 1'b1;
        op_d    = i2cbm_pkg::OP_IDLE;
        phase_d = '0;
      end else begin
        phase_d = phase_run + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q         <= i2cbm_pkg::OP_IDLE;
      phase_q      <= '0;
      shift_q      <= '0;
      ack_choice_q <= 1'b0;
      scl_q        <= 1'b1;
      sda_q        <= 1'b1;
      ack_flag_q   <= 1'b0;
      last_read_q  <= '0;
    end else if (step_i) begin
      op_q         <= op_d;
      phase_q      <= phase_d;
      shift_q      <= shift_d;
      ack_choice_q <= ack_choice_d;
      scl_q        <= scl_d;
      sda_q        <= sda_d;
      ack_flag_q   <= ack_flag_d;
      last_read_q  <= last_read_d;
    end
  end

  assign res_o.scl       = scl_d;
  assign res_o.sda       = sda_d;
  assign res_o.busy      = busy;
  assign res_o.done      = done;
  assign res_o.read_data = last_read_d;
  assign res_o.ack_seen  = ack_flag_d;

`ifndef NO_ASSERTIONS
  // phase counter rests at zero between commands
  a_idle_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_q == i2cbm_pkg::OP_IDLE |-> phase_q == '0)
    else $error("phase count not zero while idle");

  // no command runs past its last phase
  a_phase_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= i2cbm_pkg::LAST_READ)
    else $error("phase count out of range");

  // start and stop are three phases long
  a_short_ops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_q == i2cbm_pkg::OP_START || op_q == i2cbm_pkg::OP_STOP)
      |-> phase_q <= i2cbm_pkg::LAST_START)
    else $error("start or stop ran too long");
`endif

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the byte-level i2c master sequencer against a cycle-free bus phase
// predictor: start, stop, write, read, unused and dropped commands, idle
// ticks, then random bus transactions under input gaps and output stalls
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned TargetTicks   = 850;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles   = 4;

  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       in_valid_i   = 1'b0;
  logic [2:0] command_i    = i2cbm_pkg::CMD_NONE;
  logic [7:0] write_data_i = 8'h00;
  logic       send_ack_i   = 1'b0;
  logic       sda_in_i     = 1'b1;
  logic       out_ready_i  = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic       scl_out_o;
  logic       sda_out_o;
  logic       busy_res_o;
  logic       done_res_o;
  logic [7:0] read_data_o;
  logic       ack_seen_o;

  i2c_bit_level_master_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .write_data_i(write_data_i),
    .send_ack_i  (send_ack_i),
    .sda_in_i    (sda_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .scl_out_o   (scl_out_o),
    .sda_out_o   (sda_out_o),
    .busy_res_o  (busy_res_o),
    .done_res_o  (done_res_o),
    .read_data_o (read_data_o),
    .ack_seen_o  (ack_seen_o)
  );

  // predicted sequencer state, reset values as after rst_ni
  i2cbm_pkg::op_e seq_op         = i2cbm_pkg::OP_IDLE;
  logic [4:0]     seq_phase      = '0;
  logic [7:0]     seq_shift      = '0;
  logic           seq_ack_choice = 1'b0;
  logic           seq_scl        = 1'b1;
  logic           seq_sda        = 1'b1;
  logic           seq_ack_flag   = 1'b0;
  logic [7:0]     seq_last_read  = '0;

  // result beats predicted but not yet seen on the output
  i2cbm_pkg::res_t expected_beats[$];
  int unsigned     mismatch_count = 0;
  int unsigned     command_ticks  = 0;
  int unsigned     burst_left     = 0;
  int unsigned     idle_cycles    = 0;

  // receiver stall pattern state
  int unsigned stall_mode     = 0;
  int unsigned stall_span     = 0;
  logic [7:0]  stall_pattern  = 8'b1101_1010;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // advance the predicted sequencer by one tick and return the result beat
  function automatic i2cbm_pkg::res_t step_sequencer(logic [2:0] cmd, logic [7:0] wdata,
                                                     logic ack_req, logic sda_sample);
    i2cbm_pkg::res_t                  beat;
    logic [i2cbm_pkg::PhaseW-1:0]     last_phase;
    beat = '0;
    // a new command is only taken while idle, unused codes act as none
    if (seq_op == i2cbm_pkg::OP_IDLE) begin
      case (cmd)
        i2cbm_pkg::CMD_START: begin
          seq_op    = i2cbm_pkg::OP_START;
          seq_phase = '0;
        end
        i2cbm_pkg::CMD_STOP: begin
          seq_op    = i2cbm_pkg::OP_STOP;
          seq_phase = '0;
        end
        i2cbm_pkg::CMD_WRITE: begin
          seq_op    = i2cbm_pkg::OP_WRITE;
          seq_phase = '0;
          seq_shift = wdata;
        end
        i2cbm_pkg::CMD_READ: begin
          seq_op         = i2cbm_pkg::OP_READ;
          seq_phase      = '0;
          seq_shift      = '0;
          seq_ack_choice = ack_req;
        end
        default: ;
      endcase
    end

    if (seq_op != i2cbm_pkg::OP_IDLE) begin
      beat.busy = 1'b1;
      case (seq_op)
        i2cbm_pkg::OP_START: begin
          last_phase = i2cbm_pkg::LAST_START;
          if (seq_phase == 0) begin
            seq_sda = 1'b1;
            seq_scl = 1'b1;
          end else if (seq_phase == 1) begin
            seq_sda = 1'b0;
          end else begin
            seq_scl = 1'b0;
          end
        end
        i2cbm_pkg::OP_STOP: begin
          last_phase = i2cbm_pkg::LAST_STOP;
          if (seq_phase == 0) begin
            seq_sda = 1'b0;
          end else if (seq_phase == 1) begin
            seq_scl = 1'b1;
          end else begin
            seq_sda = 1'b1;
          end
        end
        i2cbm_pkg::OP_WRITE: begin
          last_phase = i2cbm_pkg::LAST_WRITE;
          if (seq_phase < i2cbm_pkg::ACK_PHASE) begin
            if (!seq_phase[0]) begin
              seq_sda = seq_shift[7];
              seq_scl = 1'b1;
            end else begin
              seq_scl   = 1'b0;
              seq_shift = {seq_shift[6:0], 1'b0};
            end
          end else if (seq_phase == i2cbm_pkg::ACK_PHASE) begin
            seq_sda = 1'b1;
            seq_scl = 1'b1;
          end else begin
            seq_scl      = 1'b0;
            seq_ack_flag = sda_sample;
          end
        end
        default: begin
          last_phase = i2cbm_pkg::LAST_READ;
          if (seq_phase < i2cbm_pkg::ACK_PHASE) begin
            if (!seq_phase[0]) begin
              seq_sda = 1'b1;
              seq_scl = 1'b1;
            end else begin
              seq_scl   = 1'b0;
              seq_shift = {seq_shift[6:0], sda_sample};
            end
          end else if (seq_phase == i2cbm_pkg::ACK_PHASE) begin
            seq_sda = ~seq_ack_choice;
            seq_scl = 1'b1;
          end else if (seq_phase == i2cbm_pkg::ACK_LOW) begin
            seq_scl = 1'b0;
          end else begin
            // trailing idle phase: the byte becomes visible on the done tick
            seq_last_read = seq_shift;
          end
        end
      endcase
      if (seq_phase >= last_phase) begin
        beat.done = 1'b1;
        seq_op    = i2cbm_pkg::OP_IDLE;
        seq_phase = '0;
      end else begin
        seq_phase = seq_phase + 1'b1;
      end
    end

    beat.scl       = seq_scl;
    beat.sda       = seq_sda;
    beat.read_data = seq_last_read;
    beat.ack_seen  = seq_ack_flag;
    return beat;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // input beats feed the predictor, output beats are checked in order
  always @(posedge clk_i) begin : check_beats
    i2cbm_pkg::res_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_beats.push_back(step_sequencer(command_i, write_data_i, send_ack_i,
                                                sda_in_i));
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_beats.size() == 0) begin
          $error("result beat with no tick pending");
          mismatch_count++;
        end else begin
          want = expected_beats.pop_front();
          check_field("scl_out", want.scl, scl_out_o);
          check_field("sda_out", want.sda, sda_out_o);
          check_field("busy_res", want.busy, busy_res_o);
          check_field("done_res", want.done, done_res_o);
          check_field("read_data", want.read_data, read_data_o);
          check_field("ack_seen", want.ack_seen, ack_seen_o);
        end
      end
    end
  end

  // watchdog: too long without any beat on either side ends the run
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: switches between always ready, random stalls and a rotating pattern
  always @(posedge clk_i) begin
    if (stall_span == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_span <= $urandom_range(16, 96);
    end else begin
      stall_span <= stall_span - 1;
    end
    stall_pattern <= {stall_pattern[6:0], stall_pattern[7]};
    case (stall_mode)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= ($urandom_range(0, 9) > 2);
      default: out_ready_i <= stall_pattern[0];
    endcase
  end

  // one input beat; the sender goes quiet between bursts of random length
  task automatic send_tick(logic [2:0] cmd, logic [7:0] wdata, logic ack_req,
                           logic sda_level);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    write_data_i <= wdata;
    send_ack_i   <= ack_req;
    sda_in_i     <= sda_level;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // hold off the sender until every predicted beat has come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_beats.size() != 0) @(posedge clk_i);
  endtask

  // one command from its first tick to its done tick; noisy ticks carry
  // random commands that the busy sequencer must drop
  task automatic run_command(logic [2:0] cmd, logic [7:0] wdata, logic ack_req,
                             logic [7:0] slave_byte, logic slave_ack, bit noisy);
    int unsigned ticks;
    logic [2:0]  c;
    logic [7:0]  wd;
    logic        ak;
    logic        sda_level;
    case (cmd)
      i2cbm_pkg::CMD_START, i2cbm_pkg::CMD_STOP: ticks = i2cbm_pkg::LAST_START + 1;
      i2cbm_pkg::CMD_WRITE:                      ticks = i2cbm_pkg::LAST_WRITE + 1;
      i2cbm_pkg::CMD_READ:                       ticks = i2cbm_pkg::LAST_READ + 1;
      default:                                   ticks = 1;
    endcase
    if (cmd inside {i2cbm_pkg::CMD_START, i2cbm_pkg::CMD_STOP, i2cbm_pkg::CMD_WRITE,
                    i2cbm_pkg::CMD_READ}) command_ticks += ticks;
    for (int i = 0; i < ticks; i++) begin
      if (i == 0) begin
        c  = cmd;
        wd = wdata;
        ak = ack_req;
      end else begin
        c  = noisy ? 3'($urandom_range(0, 7)) : i2cbm_pkg::CMD_NONE;
        wd = 8'($urandom);
        ak = 1'($urandom);
      end
      // slave data bits land on the scl-low phases, the ack on the last write phase
      if (cmd == i2cbm_pkg::CMD_READ && i < i2cbm_pkg::ACK_PHASE && i[0])
        sda_level = slave_byte[7 - i / 2];
      else if (cmd == i2cbm_pkg::CMD_WRITE && i == i2cbm_pkg::LAST_WRITE)
        sda_level = slave_ack;
      else sda_level = 1'($urandom);
      send_tick(c, wd, ak, sda_level);
    end
  endtask

  task automatic idle_ticks(int unsigned n);
    for (int i = 0; i < n; i++)
      send_tick(i2cbm_pkg::CMD_NONE, 8'($urandom), 1'($urandom), 1'($urandom));
  endtask

  // start and stop framing, with idle ticks holding the lines
  task automatic test_start_stop();
    run_command(i2cbm_pkg::CMD_START, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
    idle_ticks(2);
    run_command(i2cbm_pkg::CMD_STOP, 8'hff, 1'b1, 8'h00, 1'b0, 1'b0);
    idle_ticks(1);
  endtask

  // codes 5 to 7 must behave as none
  task automatic test_unused_codes();
    run_command(3'd5, 8'hff, 1'b1, 8'h00, 1'b0, 1'b0);
    run_command(3'd6, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
    run_command(3'd7, 8'haa, 1'b1, 8'h00, 1'b0, 1'b0);
  endtask

  // all-ones with nack, all-zeros with ack, and a mixed byte under dropped commands
  task automatic test_write_byte();
    run_command(i2cbm_pkg::CMD_START, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
    run_command(i2cbm_pkg::CMD_WRITE, 8'hff, 1'b0, 8'h00, 1'b1, 1'b0);
    run_command(i2cbm_pkg::CMD_WRITE, 8'h00, 1'b1, 8'h00, 1'b0, 1'b0);
    run_command(i2cbm_pkg::CMD_WRITE, 8'h5a, 1'b0, 8'h00, 1'b0, 1'b1);
    run_command(i2cbm_pkg::CMD_STOP, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
  endtask

  // ack and nack reads, extreme slave bytes, and one read under dropped commands
  task automatic test_read_byte();
    run_command(i2cbm_pkg::CMD_START, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
    run_command(i2cbm_pkg::CMD_READ, 8'h00, 1'b1, 8'hff, 1'b0, 1'b0);
    run_command(i2cbm_pkg::CMD_READ, 8'hff, 1'b0, 8'h00, 1'b0, 1'b0);
    run_command(i2cbm_pkg::CMD_READ, 8'h00, 1'b1, 8'ha5, 1'b0, 1'b1);
    run_command(i2cbm_pkg::CMD_STOP, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
  endtask

  // mostly framed transfers with random bytes, the rest stray commands and idles
  task automatic test_random_traffic();
    int unsigned n_bytes;
    logic [2:0]  op;
    while (command_ticks < TargetTicks) begin
      if ($urandom_range(0, 9) < 8) begin
        run_command(i2cbm_pkg::CMD_START, 8'($urandom), 1'($urandom), 8'h00, 1'b0,
                    1'($urandom_range(0, 3) == 0));
        n_bytes = $urandom_range(1, 4);
        for (int b = 0; b < n_bytes; b++) begin
          op = $urandom_range(0, 1) ? i2cbm_pkg::CMD_WRITE : i2cbm_pkg::CMD_READ;
          run_command(op, 8'($urandom), 1'($urandom), 8'($urandom), 1'($urandom),
                      1'($urandom_range(0, 2) == 0));
          if ($urandom_range(0, 4) == 0) idle_ticks($urandom_range(1, 3));
        end
        run_command(i2cbm_pkg::CMD_STOP, 8'($urandom), 1'($urandom), 8'h00, 1'b0,
                    1'($urandom_range(0, 3) == 0));
      end else begin
        run_command(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom), 8'($urandom),
                    1'($urandom), 1'($urandom));
        idle_ticks($urandom_range(0, 3));
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_start_stop();
    test_unused_codes();
    test_write_byte();
    test_read_byte();
    // let the pipe run dry once before the random part
    wait_drained();
    test_random_traffic();

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (expected_beats.size() != 0) begin
      $error("%0d result beats never arrived", expected_beats.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
